// ===== rtl/mdtd_pkg.sv =====
// Shared types and constants for the broadcast date and time decoder.
// Used by mdtd_date_pipe and mjd_bcd_date_time_decode_unit; depends on nothing.
package mdtd_pkg;

   // Request and response payloads.
   typedef struct packed {
      logic [15:0] mjd;
      logic [23:0] bcd_time;
   } req_type;

   typedef struct packed {
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } clk_time_type;

   typedef struct packed {
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } rsp_type;

   // Sideband between the top level and the date pipeline.
   typedef struct packed {
      logic        valid;
      logic [15:0] mjd;
   } date_req_type;

   typedef struct packed {
      logic     valid;
      date_type date;
   } date_rsp_type;

   // Register stages from an accepted transfer to the result strobe.
   localparam int LAT = 11;

   // Year estimate: (100*mjd - 1507820) / 36525.
   localparam logic [22:0] YR_NUM_OFS = 23'd1507820;
   localparam logic [15:0] MJD_YR_SPLIT = 16'd15079;
   localparam logic [23:0] YR_DIV = 24'd36525;
   localparam logic [16:0] YR_RECIP = 17'd117589;   // floor(2^32 / 36525)
   localparam logic [10:0] DAYS_4YR = 11'd1461;

   // Month estimate: (10000*e - 1000) / 306001.
   localparam logic [19:0] MJD_OFS = 20'd14956;
   localparam logic [23:0] MO_DIV = 24'd306001;
   localparam logic [13:0] MO_RECIP = 14'd14035;    // floor(2^32 / 306001)

   localparam logic [11:0] CENTURY_BASE = 12'd1900;
   localparam logic [11:0] YEAR_FLOOR = 12'd1970;

   // trunc(m * 30.6001) for a month index magnitude.
   function automatic logic [8:0] month_span(input logic [3:0] m);
      logic [8:0] r;
      begin
         case (m)
            4'd0: r = 9'd0;
            4'd1: r = 9'd30;
            4'd2: r = 9'd61;
            4'd3: r = 9'd91;
            4'd4: r = 9'd122;
            4'd5: r = 9'd153;
            4'd6: r = 9'd183;
            4'd7: r = 9'd214;
            4'd8: r = 9'd244;
            4'd9: r = 9'd275;
            4'd10: r = 9'd306;
            4'd11: r = 9'd336;
            4'd12: r = 9'd367;
            4'd13: r = 9'd397;
            4'd14: r = 9'd428;
            4'd15: r = 9'd459;
            default: r = 9'd0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== rtl/mdtd_date_pipe.sv =====
// Pipelined day number to calendar date conversion, one transfer per cycle.
// Depends on mdtd_pkg for types and the scaled-integer constants.
module mdtd_date_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  mdtd_pkg::date_req_type req_in,
   output mdtd_pkg::date_rsp_type rsp_out
);

   logic [mdtd_pkg::LAT-1:0] v_ff, v_in;

   // Stage 1: numerator of the year estimate, split into sign and magnitude.
   logic [22:0] a1_ff, a1_in, x100;
   logic        n1_ff, n1_in;
   logic [15:0] mjd1_ff;
   // Stage 2: reciprocal product, quotient estimate.
   logic [39:0] p2;
   logic [7:0]  qe2_ff, qe2_in;
   logic [22:0] a2_ff;
   logic        n2_ff;
   logic [15:0] mjd2_ff;
   // Stage 3: back multiplication.
   logic [23:0] m3_ff, m3_in;
   logic [7:0]  qe3_ff;
   logic [22:0] a3_ff;
   logic        n3_ff;
   logic [15:0] mjd3_ff;
   // Stage 4: corrected year magnitude.
   logic [23:0] r4;
   logic [8:0]  q4_ff, q4_in;
   logic        n4_ff;
   logic [15:0] mjd4_ff;
   // Stage 5: magnitude of trunc(yr * 365.25).
   logic [19:0] bp5;
   logic [17:0] bm5_ff, bm5_in;
   logic [8:0]  q5_ff;
   logic        n5_ff;
   logic [15:0] mjd5_ff;
   // Stage 6: days into the year window, signed year.
   logic signed [19:0] e6_wide;
   logic signed [10:0] e6_ff, e6_in;
   logic signed [9:0]  yr6_ff, yr6_in;
   // Stage 7: month numerator magnitude.
   logic signed [25:0] n7_wide;
   logic [22:0]        b7_ff, b7_in;
   logic               s7_ff, s7_in;
   logic signed [10:0] e7_ff;
   logic signed [9:0]  yr7_ff;
   // Stage 8: reciprocal product for the month.
   logic [36:0]        p8;
   logic [4:0]         qe8_ff, qe8_in;
   logic [22:0]        b8_ff;
   logic               s8_ff;
   logic signed [10:0] e8_ff;
   logic signed [9:0]  yr8_ff;
   // Stage 9: back multiplication for the month.
   logic [23:0]        m9_ff, m9_in;
   logic [4:0]         qe9_ff;
   logic [22:0]        b9_ff;
   logic               s9_ff;
   logic signed [10:0] e9_ff;
   logic signed [9:0]  yr9_ff;
   // Stage 10: signed month index.
   logic [23:0]        r10;
   logic [5:0]         q10;
   logic signed [6:0]  mo10_ff, mo10_in;
   logic signed [10:0] e10_ff;
   logic signed [9:0]  yr10_ff;
   // Stage 11: final date with range clamps.
   logic [3:0]          mo_mag;
   logic signed [10:0]  span;
   logic signed [10:0]  day_raw;
   logic signed [11:0]  year_raw;
   logic signed [6:0]   month_raw;
   logic                k11;
   mdtd_pkg::date_type  date_ff, date_in;

   assign v_in = {v_ff[mdtd_pkg::LAT-2:0], req_in.valid};

   always_comb begin
      x100 = 23'(req_in.mjd) * 23'd100;
      n1_in = req_in.mjd < mdtd_pkg::MJD_YR_SPLIT;
      a1_in = n1_in ? (mdtd_pkg::YR_NUM_OFS - x100) : (x100 - mdtd_pkg::YR_NUM_OFS);
   end

   always_comb begin
      p2 = 40'(a1_ff) * 40'(mdtd_pkg::YR_RECIP);
      qe2_in = p2[39:32];
      m3_in = 24'(qe2_ff) * mdtd_pkg::YR_DIV;
   end

   always_comb begin
      r4 = {1'b0, a3_ff} - m3_ff;
      q4_in = {1'b0, qe3_ff} + ((r4 >= mdtd_pkg::YR_DIV) ? 9'd1 : 9'd0);
      bp5 = 20'(q4_ff) * 20'(mdtd_pkg::DAYS_4YR);
      bm5_in = bp5[19:2];
   end

   // Base is negative exactly when the year is, so e = mjd - 14956 - base.
   always_comb begin
      e6_wide = signed'({4'd0, mjd5_ff}) - signed'(mdtd_pkg::MJD_OFS)
              + (n5_ff ? signed'({2'd0, bm5_ff}) : -signed'({2'd0, bm5_ff}));
      e6_in = e6_wide[10:0];
      yr6_in = n5_ff ? -signed'({1'b0, q5_ff}) : signed'({1'b0, q5_ff});
   end

   always_comb begin
      n7_wide = 26'(e6_ff) * 26'sd10000 - 26'sd1000;
      s7_in = n7_wide < 0;
      b7_in = s7_in ? 23'(-n7_wide) : 23'(n7_wide);
      p8 = 37'(b7_ff) * 37'(mdtd_pkg::MO_RECIP);
      qe8_in = p8[36:32];
      m9_in = 24'(qe8_ff) * mdtd_pkg::MO_DIV;
   end

   always_comb begin
      r10 = {1'b0, b9_ff} - m9_ff;
      q10 = {1'b0, qe9_ff} + ((r10 >= mdtd_pkg::MO_DIV) ? 6'd1 : 6'd0);
      mo10_in = s9_ff ? -signed'({1'b0, q10}) : signed'({1'b0, q10});
   end

   always_comb begin
      mo_mag = mo10_ff[6] ? 4'(-mo10_ff) : mo10_ff[3:0];
      span = mo10_ff[6] ? -signed'({2'd0, mdtd_pkg::month_span(mo_mag)})
                        : signed'({2'd0, mdtd_pkg::month_span(mo_mag)});
      day_raw = e10_ff - span;
      k11 = (mo10_ff == 7'sd14) || (mo10_ff == 7'sd15);
      year_raw = 12'(yr10_ff) + signed'(mdtd_pkg::CENTURY_BASE) + (k11 ? 12'sd1 : 12'sd0);
      month_raw = mo10_ff - 7'sd1 - (k11 ? 7'sd12 : 7'sd0);
      date_in.year = (year_raw < signed'(mdtd_pkg::YEAR_FLOOR)) ?
                     mdtd_pkg::YEAR_FLOOR[10:0] : year_raw[10:0];
      date_in.month = (month_raw < 7'sd1 || month_raw > 7'sd12) ? 4'd1 : month_raw[3:0];
      date_in.day = (day_raw < 11'sd1 || day_raw > 11'sd31) ? 5'd1 : day_raw[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff <= a1_in;   n1_ff <= n1_in;   mjd1_ff <= req_in.mjd;
      qe2_ff <= qe2_in; a2_ff <= a1_ff;   n2_ff <= n1_ff; mjd2_ff <= mjd1_ff;
      m3_ff <= m3_in;   qe3_ff <= qe2_ff; a3_ff <= a2_ff; n3_ff <= n2_ff;
      mjd3_ff <= mjd2_ff;
      q4_ff <= q4_in;   n4_ff <= n3_ff;   mjd4_ff <= mjd3_ff;
      bm5_ff <= bm5_in; q5_ff <= q4_ff;   n5_ff <= n4_ff; mjd5_ff <= mjd4_ff;
      e6_ff <= e6_in;   yr6_ff <= yr6_in;
      b7_ff <= b7_in;   s7_ff <= s7_in;   e7_ff <= e6_ff; yr7_ff <= yr6_ff;
      qe8_ff <= qe8_in; b8_ff <= b7_ff;   s8_ff <= s7_ff; e8_ff <= e7_ff;
      yr8_ff <= yr7_ff;
      m9_ff <= m9_in;   qe9_ff <= qe8_ff; b9_ff <= b8_ff; s9_ff <= s8_ff;
      e9_ff <= e8_ff;   yr9_ff <= yr8_ff;
      mo10_ff <= mo10_in; e10_ff <= e9_ff; yr10_ff <= yr9_ff;
      date_ff <= date_in;
   end

   assign rsp_out.valid = v_ff[mdtd_pkg::LAT-1];
   assign rsp_out.date = date_ff;

endmodule

// ===== rtl/mjd_bcd_date_time_decode_unit.sv =====
// Top level of the broadcast date and time decoder: BCD time decode and result port.
// Depends on mdtd_pkg and instantiates mdtd_date_pipe.
//
//   Channel   Ports                       Handshake
//   request   start, busy, req_data       transfer when start is high and busy is low
//   response  rsp_valid, rsp_data         one-cycle strobe, always taken
//
// Every request transfer yields exactly one response, in order. A new transfer may
// occur in every cycle in which busy is low; the eleven register stages of the date
// conversion (two reciprocal divisions, each an estimate multiply, a back multiply and
// a correction) lie between transfer and response. The time digits are decoded in the
// first stage and ride a matching delay line. Reset is synchronous and active high; it
// empties the pipeline, and busy stays high for the cycle after reset is released. The
// receiver cannot stall, so nothing inside the block ever waits.
module mjd_bcd_date_time_decode_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mdtd_pkg::req_type req_data,
   output logic              rsp_valid,
   output mdtd_pkg::rsp_type rsp_data
);

   logic                   busy_ff;
   logic                   accept;
   mdtd_pkg::date_req_type date_req;
   mdtd_pkg::date_rsp_type date_rsp;
   mdtd_pkg::clk_time_type tdec_in;
   mdtd_pkg::clk_time_type tline_ff [mdtd_pkg::LAT];

   // Hour pair reduced mod 24; the quotient uses 171/4096, exact for values up to 165.
   function automatic logic [4:0] hour_of(input logic [7:0] digits);
      logic [7:0]  v;
      logic [15:0] p;
      logic [7:0]  sub;
      begin
         v = 8'(digits[7:4]) * 8'd10 + 8'(digits[3:0]);
         p = 16'(v) * 16'd171;
         sub = 8'(p[15:12]) * 8'd24;
         return 5'(v - sub);
      end
   endfunction

   // Minute and second pairs never exceed 165, so two thresholds cover mod 60.
   function automatic logic [5:0] sexa_of(input logic [7:0] digits);
      logic [7:0] v;
      logic [7:0] r;
      begin
         v = 8'(digits[7:4]) * 8'd10 + 8'(digits[3:0]);
         if (v >= 8'd120) begin
            r = v - 8'd120;
         end else if (v >= 8'd60) begin
            r = v - 8'd60;
         end else begin
            r = v;
         end
         return r[5:0];
      end
   endfunction

   // Busy is a registered copy of reset; while it is high the pipeline is empty.
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy = busy_ff;
   assign accept = start && !busy_ff;

   assign date_req.valid = accept;
   assign date_req.mjd = req_data.mjd;

   mdtd_date_pipe u_date (
      .clock   (clock),
      .reset   (reset),
      .req_in  (date_req),
      .rsp_out (date_rsp)
   );

   always_comb begin
      tdec_in.hour = hour_of(req_data.bcd_time[23:16]);
      tdec_in.minute = sexa_of(req_data.bcd_time[15:8]);
      tdec_in.second = sexa_of(req_data.bcd_time[7:0]);
   end

   // Time fields travel beside the date stages; the date pipeline owns the valid bits.
   always_ff @(posedge clock) begin
      tline_ff[0] <= tdec_in;
      for (int i = 1; i < mdtd_pkg::LAT; i++) begin
         tline_ff[i] <= tline_ff[i-1];
      end
   end

   assign rsp_valid = date_rsp.valid;

   always_comb begin
      rsp_data.year = date_rsp.date.year;
      rsp_data.month = date_rsp.date.month;
      rsp_data.day = date_rsp.date.day;
      rsp_data.hour = tline_ff[mdtd_pkg::LAT-1].hour;
      rsp_data.minute = tline_ff[mdtd_pkg::LAT-1].minute;
      rsp_data.second = tline_ff[mdtd_pkg::LAT-1].second;
   end

   // Every transfer comes out after the fixed latency unless reset intervenes.
   a_lat_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##11 rsp_valid)
      else $error("accepted transfer did not produce a result on time");

   // No result appears without a matching transfer.
   a_lat_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 11))
      else $error("result strobe without a matching transfer");

   // Clamps and modular reductions keep every field in its legal range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.year >= 11'd1970 && rsp_data.month >= 4'd1 &&
                     rsp_data.month <= 4'd12 && rsp_data.day >= 5'd1 &&
                     rsp_data.day <= 5'd31 && rsp_data.hour < 5'd24 &&
                     rsp_data.minute < 6'd60 && rsp_data.second < 6'd60))
      else $error("result field out of range");

   // Busy drops in the cycle after reset is released.
   a_busy: assert property (@(posedge clock) !reset |=> !busy)
      else $error("busy held without reset");

endmodule
